// ===== sv/msd_pkg.sv =====
// shared types and constants of the magic sync packet deframer
package msd_pkg;

   localparam int MaxPayload = 64;

   typedef enum logic [2:0] {
      ST_HUNT,
      ST_CMD,
      ST_LEN,
      ST_DATA,
      ST_CHECK,
      ST_DRAIN
   } state_type;

   typedef enum logic [1:0] {
      KIND_GOOD = 2'd0,
      KIND_SUM  = 2'd1,
      KIND_LEN  = 2'd2
   } kind_type;

   typedef struct packed {
      kind_type    kind;
      logic [7:0]  command;
      logic [7:0]  length;
      logic [5:0]  byte_index;
      logic [7:0]  data;
      logic [7:0]  computed_sum;
      logic        last;
   } result_type;

endpackage

// ===== sv/magic_sync_packet_deframer.sv =====
// top level of the magic sync packet deframer
// one byte is taken per cycle unless draining a packet or holding a result the receiver has not taken
// a length or checksum error result, or an empty good packet, shows in the cycle after its beat
// a good packet drains from the payload memory entry by entry: each entry is read, then loaded into
// the output register once that register is free; no bytes are taken meanwhile
// synchronous reset returns to header hunt and clears the magic pattern, not the payload memory
module magic_sync_packet_deframer #(
   parameter int MAX_PAYLOAD = msd_pkg::MaxPayload
) (
   input  logic        clock,
   input  logic        reset,
   // configuration: magic pattern, first header byte in bits 7:0
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [63:0] csr_data,
   // received bytes
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // rx_byte[7:0]
   // results
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // command[7:0], length[15:8], byte_index[21:16],
                                    // data[29:22], computed_sum[37:30], zero[39:38]
   output logic [1:0]  rsp_tuser,   // kind[1:0]
   output logic        rsp_tlast    // last
);

   localparam int AW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;

   logic [63:0]         magic_ff;
   logic                rsp_valid_ff, rsp_valid_in;
   msd_pkg::result_type rsp_ff;

   logic                out_free;
   logic                busy;
   logic                beat;
   logic                emit_valid;
   msd_pkg::result_type emit;
   logic                ram_we;
   logic [AW-1:0]       ram_waddr;
   logic [7:0]          ram_wdata;
   logic                ram_re;
   logic [AW-1:0]       ram_raddr;
   logic [7:0]          ram_rdata;

   // output register can take a result when empty or being emptied
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign req_tready = !busy && out_free;
   assign beat       = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         magic_ff <= 64'd0;
      end else if (csr_valid) begin
         magic_ff <= csr_data;
      end
   end

   msd_fsm #(
      .MAX_PAYLOAD (MAX_PAYLOAD),
      .AW          (AW)
   ) u_fsm (
      .clock      (clock),
      .reset      (reset),
      .magic      (magic_ff),
      .in_valid   (beat),
      .in_byte    (req_tdata),
      .out_free   (out_free),
      .busy       (busy),
      .emit_valid (emit_valid),
      .emit       (emit),
      .ram_we     (ram_we),
      .ram_waddr  (ram_waddr),
      .ram_wdata  (ram_wdata),
      .ram_re     (ram_re),
      .ram_raddr  (ram_raddr),
      .ram_rdata  (ram_rdata)
   );

   msd_ram #(
      .DEPTH (MAX_PAYLOAD),
      .AW    (AW)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (ram_re),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   // output register: loads a new result whenever the fsm emits one
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (emit_valid) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (emit_valid) begin
         rsp_ff <= emit;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {2'b00, rsp_ff.computed_sum, rsp_ff.data, rsp_ff.byte_index,
                        rsp_ff.length, rsp_ff.command};
   assign rsp_tuser  = rsp_ff.kind;
   assign rsp_tlast  = rsp_ff.last;

endmodule

// ===== sv/msd_ram.sv =====
// payload store: one write port, one registered read port
module msd_ram #(
   parameter int DEPTH = msd_pkg::MaxPayload,
   parameter int AW    = 6
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic [7:0]    wr_data,
   input  logic          rd_en,
   input  logic [AW-1:0] rd_addr,
   output logic [7:0]    rd_data
);

   logic [7:0] mem [DEPTH];
   logic [7:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // read data holds until the next read
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== sv/msd_fsm.sv =====
// framing control: header hunt, payload fill, checksum check and drain
module msd_fsm #(
   parameter int MAX_PAYLOAD = msd_pkg::MaxPayload,
   parameter int AW          = 6
) (
   input  logic                clock,
   input  logic                reset,
   input  logic [63:0]         magic,
   input  logic                in_valid,
   input  logic [7:0]          in_byte,
   input  logic                out_free,
   output logic                busy,
   output logic                emit_valid,
   output msd_pkg::result_type emit,
   output logic                ram_we,
   output logic [AW-1:0]       ram_waddr,
   output logic [7:0]          ram_wdata,
   output logic                ram_re,
   output logic [AW-1:0]       ram_raddr,
   input  logic [7:0]          ram_rdata
);

   localparam int CW = $clog2(MAX_PAYLOAD + 1);

   msd_pkg::state_type state_ff, state_in;
   logic [2:0]    magic_cnt_ff, magic_cnt_in;
   logic [7:0]    cmd_ff, cmd_in;
   logic [7:0]    len_ff, len_in;
   logic [7:0]    sum_ff, sum_in;
   logic [CW-1:0] fill_ff, fill_in;
   logic [CW-1:0] drain_ff, drain_in;
   logic          rd_pend_ff, rd_pend_in;

   logic [7:0]    magic_byte;
   logic [CW-1:0] fill_nxt;
   logic          fill_done;
   logic          len_over;
   logic          sum_ok;
   logic          drain_last;
   logic          drain_emit;

   assign magic_byte = magic[{magic_cnt_ff, 3'b000} +: 8];
   assign fill_nxt   = fill_ff + 1'b1;
   assign fill_done  = 8'(fill_nxt) >= len_ff;
   assign len_over   = in_byte > 8'(MAX_PAYLOAD);
   assign sum_ok     = in_byte == sum_ff;
   assign drain_last = (8'(drain_ff) + 8'd1) == len_ff;
   assign drain_emit = (state_ff == msd_pkg::ST_DRAIN) && rd_pend_ff && out_free;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         msd_pkg::ST_HUNT: begin
            if (in_valid && in_byte == magic_byte && magic_cnt_ff == 3'd7) begin
               state_in = msd_pkg::ST_CMD;
            end
         end
         msd_pkg::ST_CMD: begin
            if (in_valid) begin
               state_in = msd_pkg::ST_LEN;
            end
         end
         msd_pkg::ST_LEN: begin
            if (in_valid) begin
               if (in_byte == 8'd0) begin
                  state_in = msd_pkg::ST_CHECK;
               end else if (len_over) begin
                  state_in = msd_pkg::ST_HUNT;
               end else begin
                  state_in = msd_pkg::ST_DATA;
               end
            end
         end
         msd_pkg::ST_DATA: begin
            if (in_valid && fill_done) begin
               state_in = msd_pkg::ST_CHECK;
            end
         end
         msd_pkg::ST_CHECK: begin
            if (in_valid) begin
               state_in = (sum_ok && len_ff != 8'd0) ? msd_pkg::ST_DRAIN : msd_pkg::ST_HUNT;
            end
         end
         msd_pkg::ST_DRAIN: begin
            if (drain_emit && drain_last) begin
               state_in = msd_pkg::ST_HUNT;
            end
         end
         default: state_in = msd_pkg::ST_HUNT;
      endcase
   end

   // datapath registers and outputs
   always_comb begin
      magic_cnt_in = magic_cnt_ff;
      cmd_in       = cmd_ff;
      len_in       = len_ff;
      sum_in       = sum_ff;
      fill_in      = fill_ff;
      drain_in     = drain_ff;
      rd_pend_in   = rd_pend_ff;
      ram_we       = 1'b0;
      ram_re       = 1'b0;
      emit_valid   = 1'b0;
      emit.kind         = msd_pkg::KIND_GOOD;
      emit.command      = cmd_ff;
      emit.length       = len_ff;
      emit.byte_index   = 6'd0;
      emit.data         = 8'd0;
      emit.computed_sum = sum_ff;
      emit.last         = 1'b1;
      case (state_ff)
         msd_pkg::ST_HUNT: begin
            if (in_valid) begin
               if (in_byte == magic_byte) begin
                  magic_cnt_in = magic_cnt_ff + 3'd1;
               end else begin
                  magic_cnt_in = (in_byte == magic[7:0]) ? 3'd1 : 3'd0;
               end
            end
         end
         msd_pkg::ST_CMD: begin
            if (in_valid) begin
               cmd_in = in_byte;
               sum_in = in_byte;
            end
         end
         msd_pkg::ST_LEN: begin
            if (in_valid) begin
               len_in  = in_byte;
               sum_in  = sum_ff ^ in_byte;
               fill_in = '0;
               if (len_over) begin
                  emit_valid        = 1'b1;
                  emit.kind         = msd_pkg::KIND_LEN;
                  emit.length       = in_byte;
                  emit.computed_sum = sum_ff ^ in_byte;
               end
            end
         end
         msd_pkg::ST_DATA: begin
            if (in_valid) begin
               ram_we  = 1'b1;
               fill_in = fill_nxt;
               sum_in  = sum_ff ^ in_byte;
            end
         end
         msd_pkg::ST_CHECK: begin
            if (in_valid) begin
               drain_in   = '0;
               rd_pend_in = 1'b0;
               if (!sum_ok) begin
                  emit_valid = 1'b1;
                  emit.kind  = msd_pkg::KIND_SUM;
               end else if (len_ff == 8'd0) begin
                  emit_valid = 1'b1;
               end
            end
         end
         msd_pkg::ST_DRAIN: begin
            if (!rd_pend_ff) begin
               ram_re     = 1'b1;
               rd_pend_in = 1'b1;
            end else if (out_free) begin
               emit_valid      = 1'b1;
               emit.byte_index = 6'(drain_ff);
               emit.data       = ram_rdata;
               emit.last       = drain_last;
               drain_in        = drain_ff + 1'b1;
               rd_pend_in      = 1'b0;
            end
         end
         default: begin
            magic_cnt_in = 3'd0;
         end
      endcase
   end

   assign busy      = state_ff == msd_pkg::ST_DRAIN;
   assign ram_waddr = fill_ff[AW-1:0];
   assign ram_wdata = in_byte;
   assign ram_raddr = drain_ff[AW-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= msd_pkg::ST_HUNT;
         magic_cnt_ff <= 3'd0;
         cmd_ff       <= 8'd0;
         len_ff       <= 8'd0;
         sum_ff       <= 8'd0;
         fill_ff      <= '0;
         drain_ff     <= '0;
         rd_pend_ff   <= 1'b0;
      end else begin
         state_ff     <= state_in;
         magic_cnt_ff <= magic_cnt_in;
         cmd_ff       <= cmd_in;
         len_ff       <= len_in;
         sum_ff       <= sum_in;
         fill_ff      <= fill_in;
         drain_ff     <= drain_in;
         rd_pend_ff   <= rd_pend_in;
      end
   end

`ifndef NO_ASSERTIONS
   a_pend_in_drain : assert property (@(posedge clock) disable iff (reset)
      rd_pend_ff |-> state_ff == msd_pkg::ST_DRAIN)
      else $error("read pending outside drain");

   a_no_beat_in_drain : assert property (@(posedge clock) disable iff (reset)
      in_valid |-> state_ff != msd_pkg::ST_DRAIN)
      else $error("input beat taken while draining");

   a_emit_needs_room : assert property (@(posedge clock) disable iff (reset)
      emit_valid |-> out_free)
      else $error("result produced with output register full");

   a_ram_one_port : assert property (@(posedge clock) disable iff (reset)
      ram_we |-> !ram_re)
      else $error("payload read and write in the same cycle");

   a_read_then_emit : assert property (@(posedge clock) disable iff (reset)
      ram_re |=> rd_pend_ff)
      else $error("payload read lost");
`endif

endmodule
